[hdl/swat_pkg.sv]
`default_nettype none

package swat_pkg;

   localparam int NODES_DEF = 32;
   localparam int SLOTS_DEF = 16;

   localparam int OP_W      = 2;
   localparam int NODE_W    = 5;
   localparam int SEQ_W     = 8;
   localparam int STATUS_W  = 3;
   localparam int FREED_W   = 5;
   localparam int FW_W      = 7;
   localparam int RSV_W     = 5;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 7;

   localparam logic [FW_W-1:0]  FLOW_WINDOW_RST    = 7'd16;
   localparam logic [RSV_W-1:0] URGENT_RESERVE_RST = 5'd10;
   localparam logic [FREED_W-1:0] FREED_MAX        = 5'd31;

   localparam logic [CSR_IDX_W-1:0] CSR_FLOW_WINDOW    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_URGENT_RESERVE = 1'd1;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC = 2'd0,
      OP_RECV  = 2'd1,
      OP_UNACK = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK           = 3'd0,
      STS_WINDOW_FULL  = 3'd1,
      STS_NO_SLOT      = 3'd2,
      STS_DUPLICATE    = 3'd3,
      STS_OUT_OF_ORDER = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOAD,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [SEQ_W-1:0] next_send;
      logic [SEQ_W-1:0] peer_acked;
      logic [SEQ_W-1:0] in_order;
   } node_entry_type;

   localparam node_entry_type NODE_ENTRY_RST = '{
      next_send:  8'd1,
      peer_acked: 8'd0,
      in_order:   8'd0
   };

   // first field in the highest bits
   typedef struct packed {
      logic [SEQ_W-1:0]    ack_to_return;
      logic [FREED_W-1:0]  freed_count;
      logic                close_request;
      logic [SEQ_W-1:0]    assigned_ack;
      logic [STATUS_W-1:0] status;
   } rsp_fields_type;

   typedef struct packed {
      logic              start;
      logic              alloc;
      logic              low_priority;
      logic [NODE_W-1:0] node;
      logic [RSV_W-1:0]  reserve;
      logic [SEQ_W-1:0]  ret;
      logic [SEQ_W-1:0]  number;
   } scan_cmd_type;

   typedef struct packed {
      logic               done;
      logic               found;
      logic [FREED_W-1:0] freed;
   } scan_rsp_type;

   // a before b, modulo 256
   function automatic logic seq_lt(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] d;
      d = a - b;
      return d[SEQ_W-1];
   endfunction

   function automatic logic seq_le(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] d;
      d = a - b;
      return (d == '0) || d[SEQ_W-1];
   endfunction

   function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] a);
      logic [SEQ_W-1:0] n;
      n = a + 8'd1;
      if (n == '0) begin
         n = 8'd1;
      end
      return n;
   endfunction

   function automatic logic [SEQ_W-1:0] seq_dec(input logic [SEQ_W-1:0] a);
      logic [SEQ_W-1:0] n;
      n = a - 8'd1;
      if (n == '0) begin
         n = 8'hFF;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

[hdl/swat_slot_scan.sv]
`default_nettype none

module swat_slot_scan
   import swat_pkg::*;
#(
   parameter int NODES = NODES_DEF,
   parameter int SLOTS = SLOTS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire scan_cmd_type cmd,
   output scan_rsp_type      rsp
);

   localparam int NW    = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW    = $clog2(SLOTS + 1);
   localparam int DEPTH = NODES * SLOTS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int KW    = (CW > RSV_W) ? CW : RSV_W;

   logic [SEQ_W-1:0]   slot_mem [DEPTH];

   scan_cmd_type       cmd_ff;
   logic               busy_ff;
   logic [CW-1:0]      rd_cnt_ff;
   logic               pend_ff;
   logic [SW-1:0]      pend_idx_ff;
   logic [SEQ_W-1:0]   rd_data_ff;
   logic               found_ff, found_in;
   logic [CW-1:0]      seen_ff, seen_in;
   logic [FREED_W-1:0] freed_ff, freed_in;
   logic               done_ff;
   logic [NODES-1:0]   row_vld_ff;

   logic [NW-1:0]      node_idx;
   logic               issue;
   logic               last;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [SEQ_W-1:0]   cur;
   logic [SEQ_W-1:0]   wr_val;
   logic [CW-1:0]      seen_inc;

   assign node_idx = NW'(cmd_ff.node);
   assign issue    = busy_ff && (rd_cnt_ff < CW'(SLOTS));
   assign last     = pend_ff && (pend_idx_ff == SW'(SLOTS - 1));
   assign rd_addr  = AW'(node_idx) * AW'(SLOTS) + AW'(rd_cnt_ff[SW-1:0]);
   assign wr_addr  = AW'(node_idx) * AW'(SLOTS) + AW'(pend_idx_ff);
   assign cur      = row_vld_ff[node_idx] ? rd_data_ff : '0;
   assign seen_inc = seen_ff + CW'(1);

   always_comb begin
      wr_val   = cur;
      found_in = found_ff;
      seen_in  = seen_ff;
      freed_in = freed_ff;
      if (pend_ff) begin
         if (cmd_ff.alloc) begin
            if ((cur == '0) && !found_ff) begin
               if (cmd_ff.low_priority) begin
                  seen_in = seen_inc;
                  if (KW'(seen_inc) > KW'(cmd_ff.reserve)) begin
                     wr_val   = cmd_ff.number;
                     found_in = 1'b1;
                  end
               end else begin
                  wr_val   = cmd_ff.number;
                  found_in = 1'b1;
               end
            end
         end else begin
            if ((cur != '0) && seq_le(cur, cmd_ff.ret)) begin
               wr_val = '0;
               if (freed_ff != FREED_MAX) begin
                  freed_in = freed_ff + FREED_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         rd_cnt_ff  <= '0;
         pend_ff    <= 1'b0;
         done_ff    <= 1'b0;
         found_ff   <= 1'b0;
         seen_ff    <= '0;
         freed_ff   <= '0;
         row_vld_ff <= '0;
      end else begin
         pend_ff <= issue;
         done_ff <= last;
         if (cmd.start) begin
            busy_ff   <= 1'b1;
            rd_cnt_ff <= '0;
            found_ff  <= 1'b0;
            seen_ff   <= '0;
            freed_ff  <= '0;
         end else begin
            found_ff <= found_in;
            seen_ff  <= seen_in;
            freed_ff <= freed_in;
            if (issue) begin
               rd_cnt_ff <= rd_cnt_ff + CW'(1);
            end
            if (last) begin
               busy_ff              <= 1'b0;
               row_vld_ff[node_idx] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cmd_ff <= cmd;
      end
      pend_idx_ff <= rd_cnt_ff[SW-1:0];
   end

   // slot memory: one read and one write port
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
      if (pend_ff) begin
         slot_mem[wr_addr] <= wr_val;
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.found = found_ff;
   assign rsp.freed = freed_ff;

endmodule

`default_nettype wire

[hdl/sliding_window_ack_tracker.sv]
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  req_tdata, req_tuser
// rsp       out        rsp_tvalid/rsp_tready  rsp_tdata
// csr       in         csr_we                 csr_index, csr_wdata
//
// allocate and release run the slot memory scan, which visits one slot per
// cycle through a single compare unit
// window-full allocates, other operations and ignored releases skip the scan:
// one peer state memory read
// one transaction at a time; req_tready is high only while idle
// a result waiting in the output register holds the block in its final state
// synchronous reset; slot rows and peer entries read as reset values until written

module sliding_window_ack_tracker
   import swat_pkg::*;
#(
   parameter int NODES = NODES_DEF,
   parameter int SLOTS = SLOTS_DEF
) (
   input  wire  logic                   clock,
   input  wire  logic                   reset,
   input  wire  logic                   req_tvalid,
   output logic                         req_tready,
   input  wire  logic [REQ_TDATA_W-1:0] req_tdata,  // node_index, low_priority, ack_in, ack_return_in
   input  wire  logic [OP_W-1:0]        req_tuser,  // opcode
   output logic                         rsp_tvalid,
   input  wire  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]       rsp_tdata,  // status, assigned_ack, close_request,
                                                    // freed_count, ack_to_return
   input  wire  logic                   csr_we,
   input  wire  logic [CSR_IDX_W-1:0]   csr_index,
   input  wire  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;

   node_entry_type     node_mem [NODES];

   state_type          state_ff, state_in;
   logic [FW_W-1:0]    flow_window_ff;
   logic [RSV_W-1:0]   urgent_reserve_ff;
   opcode_type         op_ff;
   logic [NODE_W-1:0]  node_ff;
   logic               lowp_ff;
   logic [SEQ_W-1:0]   ack_ff;
   logic [SEQ_W-1:0]   ret_ff;
   logic               oor_ff;
   node_entry_type     node_rd_ff;
   logic [NODES-1:0]   node_vld_ff;
   node_entry_type     ent_ff, ent_in;
   rsp_fields_type     res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_fields_type     rsp_data_ff;

   logic [NODE_W-1:0]  req_node;
   logic               accept;
   logic [NW-1:0]      rd_idx;
   logic [NW-1:0]      node_idx;
   node_entry_type     cur;
   logic [SEQ_W-1:0]   limit;
   logic [SEQ_W-1:0]   nx;
   logic               load;
   logic               wb;
   scan_cmd_type       scan_cmd;
   scan_rsp_type       scan_rsp;

   assign req_node   = req_tdata[4:0];
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rd_idx     = NW'(req_node);
   assign node_idx   = NW'(node_ff);
   assign cur        = node_vld_ff[node_idx] ? node_rd_ff : NODE_ENTRY_RST;
   assign limit      = cur.peer_acked + SEQ_W'(flow_window_ff);
   assign nx         = seq_inc(cur.in_order);

   swat_slot_scan #(
      .NODES (NODES),
      .SLOTS (SLOTS)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .cmd   (scan_cmd),
      .rsp   (scan_rsp)
   );

   always_comb begin
      state_in              = state_ff;
      ent_in                = ent_ff;
      res_in                = res_ff;
      load                  = 1'b0;
      wb                    = 1'b0;
      scan_cmd.start        = 1'b0;
      scan_cmd.alloc        = (op_ff == OP_ALLOC);
      scan_cmd.low_priority = lowp_ff;
      scan_cmd.node         = node_ff;
      scan_cmd.reserve      = urgent_reserve_ff;
      scan_cmd.ret          = ret_ff;
      scan_cmd.number       = cur.next_send;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            ent_in   = cur;
            res_in   = '0;
            state_in = S_DONE;
            if (!oor_ff) begin
               unique case (op_ff)
                  OP_ALLOC: begin
                     if (seq_lt(limit, cur.next_send)) begin
                        res_in.status = STS_WINDOW_FULL;
                     end else begin
                        scan_cmd.start = 1'b1;
                        state_in       = S_SCAN;
                     end
                  end
                  OP_RECV: begin
                     if ((ret_ff != '0) && seq_lt(cur.peer_acked, ret_ff)) begin
                        ent_in.peer_acked = ret_ff;
                        scan_cmd.start    = 1'b1;
                        state_in          = S_SCAN;
                     end
                     if (ack_ff != '0) begin
                        if (seq_le(ack_ff, cur.in_order)) begin
                           res_in.status = STS_DUPLICATE;
                        end else if (ack_ff == nx) begin
                           ent_in.in_order = nx;
                        end else begin
                           res_in.status = STS_OUT_OF_ORDER;
                        end
                     end
                  end
                  OP_UNACK: begin
                     if (node_ff != '0) begin
                        ent_in.in_order = seq_dec(cur.in_order);
                     end
                  end
                  default: begin
                  end
               endcase
               res_in.ack_to_return = ent_in.in_order;
            end
         end
         S_SCAN: begin
            if (scan_rsp.done) begin
               state_in = S_DONE;
               if (op_ff == OP_ALLOC) begin
                  if (scan_rsp.found) begin
                     res_in.assigned_ack = ent_ff.next_send;
                     ent_in.next_send    = seq_inc(ent_ff.next_send);
                  end else begin
                     res_in.status        = STS_NO_SLOT;
                     res_in.close_request = !lowp_ff;
                  end
               end else begin
                  res_in.freed_count = scan_rsp.freed;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load     = 1'b1;
               wb       = !oor_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         rsp_valid_ff      <= 1'b0;
         node_vld_ff       <= '0;
         flow_window_ff    <= FLOW_WINDOW_RST;
         urgent_reserve_ff <= URGENT_RESERVE_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wb) begin
            node_vld_ff[node_idx] <= 1'b1;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_FLOW_WINDOW:    flow_window_ff    <= csr_wdata[FW_W-1:0];
               CSR_URGENT_RESERVE: urgent_reserve_ff <= csr_wdata[RSV_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= opcode_type'(req_tuser);
         node_ff <= req_node;
         lowp_ff <= req_tdata[5];
         ack_ff  <= req_tdata[13:6];
         ret_ff  <= req_tdata[21:14];
         oor_ff  <= (32'(req_node) >= 32'(NODES));
      end
      ent_ff <= ent_in;
      res_ff <= res_in;
      if (load) begin
         rsp_data_ff <= res_ff;
      end
   end

   // peer state memory
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) begin
         node_rd_ff <= node_mem[rd_idx];
      end
      if (wb) begin
         node_mem[node_idx] <= ent_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - $bits(rsp_fields_type))'(0), rsp_data_ff};

endmodule

`default_nettype wire

[hdl/swat_port_checker.sv]
`default_nettype none

module swat_port_checker
   import swat_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // one transaction in flight: busy right after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a transaction is in flight");

   // only a successful allocate hands out a number
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] != STS_OK) |-> (rsp_tdata[10:3] == '0))
      else $error("sequence number given with a failing status");

   // close request only comes with a slot miss
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11] |-> (rsp_tdata[2:0] == STS_NO_SLOT))
      else $error("close request without slot miss");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed under stall");

endmodule

bind sliding_window_ack_tracker swat_port_checker u_port_checker (.*);

`default_nettype wire

[test/sliding_window_ack_tracker_tb.sv]
`timescale 1ns / 1ps

module sliding_window_ack_tracker_tb;
   import swat_pkg::*;

   localparam int NODES       = NODES_DEF;
   localparam int SLOTS       = SLOTS_DEF;
   localparam int HOLD_CYCLES = 300;
   localparam int STUCK_LIMIT = 3000;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;  // node_index, low_priority, ack_in, ack_return_in
   logic [OP_W-1:0]        req_tuser;  // opcode
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // status, assigned_ack, close_request,
                                       // freed_count, ack_to_return
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // shadow of the tracker state
   logic [SEQ_W-1:0] next_send [NODES];
   logic [SEQ_W-1:0] peer_acked [NODES];
   logic [SEQ_W-1:0] in_order_num [NODES];
   logic [SEQ_W-1:0] slot_num [NODES][SLOTS];
   logic [FW_W-1:0]  flow_window;
   logic [RSV_W-1:0] urgent_reserve;

   rsp_fields_type verdict_q [$];

   int  error_count;
   int  sent_count;
   int  checked_count;
   int  stuck_cycles;
   bit  quiet;
   bit  hold_request;

   sliding_window_ack_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // modulo-256 ordering of sequence numbers
   function automatic bit number_precedes(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] gap;
      gap = a - b;
      return gap >= 8'd128;
   endfunction

   function automatic bit number_not_after(input logic [SEQ_W-1:0] a,
                                           input logic [SEQ_W-1:0] b);
      return (a == b) || number_precedes(a, b);
   endfunction

   function automatic logic [SEQ_W-1:0] number_next(input logic [SEQ_W-1:0] a);
      return (a == 8'hFF) ? 8'd1 : a + 8'd1;
   endfunction

   function automatic logic [SEQ_W-1:0] number_prev(input logic [SEQ_W-1:0] a);
      return (a == 8'd1 || a == 8'd0) ? 8'hFF : a - 8'd1;
   endfunction

   function automatic rsp_fields_type track_transaction(input logic [OP_W-1:0] op,
                                                        input logic [NODE_W-1:0] node,
                                                        input logic lowp,
                                                        input logic [SEQ_W-1:0] data_num,
                                                        input logic [SEQ_W-1:0] ret_num);
      rsp_fields_type   r;
      logic [SEQ_W-1:0] limit;
      int unsigned      free_seen;
      bit               placed;
      r = '0;
      case (op)
         OP_ALLOC: begin
            limit = peer_acked[node] + SEQ_W'(flow_window);
            if (number_precedes(limit, next_send[node])) begin
               r.status = STS_WINDOW_FULL;
            end else begin
               free_seen = 0;
               placed = 1'b0;
               for (int i = 0; i < SLOTS && !placed; i++) begin
                  if (slot_num[node][i] == 8'd0) begin
                     if (lowp) free_seen++;
                     if (!lowp || free_seen > 32'(urgent_reserve)) begin
                        r.assigned_ack = next_send[node];
                        slot_num[node][i] = next_send[node];
                        next_send[node] = number_next(next_send[node]);
                        placed = 1'b1;
                     end
                  end
               end
               if (!placed) begin
                  r.status = STS_NO_SLOT;
                  r.close_request = !lowp;
               end
            end
         end
         OP_RECV: begin
            if (ret_num != 8'd0 && number_precedes(peer_acked[node], ret_num)) begin
               peer_acked[node] = ret_num;
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_num[node][i] != 8'd0 &&
                      number_not_after(slot_num[node][i], ret_num)) begin
                     slot_num[node][i] = 8'd0;
                     if (r.freed_count != FREED_MAX) r.freed_count = r.freed_count + 5'd1;
                  end
               end
            end
            if (data_num != 8'd0) begin
               if (number_not_after(data_num, in_order_num[node])) begin
                  r.status = STS_DUPLICATE;
               end else if (data_num == number_next(in_order_num[node])) begin
                  in_order_num[node] = data_num;
               end else begin
                  r.status = STS_OUT_OF_ORDER;
               end
            end
         end
         OP_UNACK: begin
            if (node != '0) in_order_num[node] = number_prev(in_order_num[node]);
         end
         default: ;
      endcase
      r.ack_to_return = in_order_num[node];
      return r;
   endfunction

   // mostly short idle stretches, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic push_request(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] node,
                               input logic lowp, input logic [SEQ_W-1:0] data_num,
                               input logic [SEQ_W-1:0] ret_num);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, ret_num, data_num, lowp, node};
      do @(posedge clock); while (!req_tready);
      verdict_q.push_back(track_transaction(op, node, lowp, data_num, ret_num));
      sent_count++;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_settled();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_FLOW_WINDOW) flow_window = value[FW_W-1:0];
      else urgent_reserve = value[RSV_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly well-formed traffic on a few busy peers, some noise
   task automatic send_random_item();
      logic [NODE_W-1:0] node;
      logic [OP_W-1:0]   op;
      logic              lowp;
      logic [SEQ_W-1:0]  data_num;
      logic [SEQ_W-1:0]  ret_num;
      logic [SEQ_W-1:0]  span;
      int                pick;
      node = NODE_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 3)
                                                 : $urandom_range(0, NODES - 1));
      lowp = 1'($urandom_range(0, 1));
      data_num = SEQ_W'($urandom);
      ret_num = SEQ_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         op = OP_ALLOC;
      end else if (pick < 85) begin
         op = OP_RECV;
         pick = $urandom_range(0, 99);
         if (pick < 60) data_num = number_next(in_order_num[node]);
         else if (pick < 75) data_num = in_order_num[node] - SEQ_W'($urandom_range(0, 5));
         else if (pick < 85) data_num = 8'd0;
         pick = $urandom_range(0, 99);
         span = next_send[node] - peer_acked[node] - 8'd1;
         if (pick < 55 && span != 8'd0 && span < 8'd128) begin
            ret_num = peer_acked[node] + SEQ_W'($urandom_range(1, span));
         end else if (pick < 75) begin
            ret_num = 8'd0;
         end
      end else if (pick < 97) begin
         op = OP_UNACK;
      end else begin
         op = OP_UNUSED;
      end
      push_request(op, node, lowp, data_num, ret_num);
   endtask

   task automatic test_status_cases();
      push_request(OP_ALLOC, 5'd1, 1'b0, 8'd0, 8'd0);
      push_request(OP_ALLOC, 5'd1, 1'b1, 8'hFF, 8'hFF);
      wait_settled();
      write_register(CSR_FLOW_WINDOW, 7'd1);
      push_request(OP_ALLOC, 5'd5, 1'b0, 8'd0, 8'd0);
      push_request(OP_ALLOC, 5'd5, 1'b0, 8'd0, 8'd0);      // window full
      push_request(OP_RECV, 5'd5, 1'b0, 8'd1, 8'd1);
      push_request(OP_RECV, 5'd5, 1'b0, 8'd1, 8'd0);       // duplicate
      push_request(OP_RECV, 5'd5, 1'b0, 8'd3, 8'd1);       // out of order, stale return
      push_request(OP_RECV, 5'd5, 1'b0, 8'd0, 8'd0);       // no data number
      push_request(OP_RECV, 5'd5, 1'b0, 8'hFF, 8'hFF);
      push_request(OP_UNACK, 5'd0, 1'b1, 8'hFF, 8'hFF);    // peer zero untouched
      push_request(OP_UNACK, 5'd6, 1'b0, 8'd0, 8'd0);      // underflow from zero
      push_request(OP_RECV, 5'd6, 1'b0, 8'd1, 8'd0);       // zero skipped
      push_request(OP_UNACK, 5'd6, 1'b0, 8'd0, 8'd0);      // underflow from one
      push_request(OP_UNUSED, 5'd31, 1'b1, 8'hFF, 8'hFF);
      push_request(OP_RECV, 5'd9, 1'b0, 8'd0, 8'd128);     // half-space jump
      push_request(OP_ALLOC, 5'd9, 1'b0, 8'd0, 8'd0);
      wait_settled();
      write_register(CSR_URGENT_RESERVE, 7'h70 | 7'd16);   // upper bits dropped
      push_request(OP_ALLOC, 5'd8, 1'b1, 8'd0, 8'd0);      // low-priority miss
      push_request(OP_ALLOC, 5'd31, 1'b0, 8'd0, 8'd0);
      wait_settled();
   endtask

   // fill the slots, miss once, release them all, until the numbers wrap
   task automatic test_number_wrap();
      wait_settled();
      write_register(CSR_FLOW_WINDOW, 7'd127);
      write_register(CSR_URGENT_RESERVE, 7'd0);
      for (int round = 0; round < 17; round++) begin
         for (int k = 0; k <= SLOTS; k++) begin
            push_request(OP_ALLOC, 5'd7, 1'($urandom_range(0, 1)), SEQ_W'($urandom),
                         SEQ_W'($urandom));
         end
         push_request(OP_RECV, 5'd7, 1'($urandom_range(0, 1)), number_next(in_order_num[7]),
                      number_prev(next_send[7]));
      end
      wait_settled();
   endtask

   task automatic test_full_stall();
      wait_settled();
      hold_request = 1'b1;
      for (int i = 0; i < 12; i++) send_random_item();
      wait_settled();
   endtask

   task automatic test_mixed_traffic(input logic [CSR_DATA_W-1:0] window,
                                     input logic [CSR_DATA_W-1:0] reserve, input int count);
      wait_settled();
      write_register(CSR_FLOW_WINDOW, window);
      write_register(CSR_URGENT_RESERVE, reserve);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
         send_random_item();
      end
      quiet = 1'b0;
      wait_settled();
   endtask

   // response side: random stalls, long hold on request
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            rsp_tready <= 1'b1;
         end else if (quiet) begin
            rsp_tready <= 1'b1;
         end else begin
            stall = pick_gap();
            if (stall == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               repeat (stall - 1) @(negedge clock);
            end
         end
      end
   end

   task automatic note_mismatch(input string what, input int want_v, input int got_v);
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
   endtask

   always @(posedge clock) begin
      rsp_fields_type got;
      rsp_fields_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got = rsp_tdata[$bits(rsp_fields_type)-1:0];
         checked_count++;
         if (verdict_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected transaction, expected none, actual %h", $time, rsp_tdata);
         end else begin
            want = verdict_q.pop_front();
            if (got.status !== want.status)
               note_mismatch("status", want.status, got.status);
            if (got.assigned_ack !== want.assigned_ack)
               note_mismatch("assigned_ack", want.assigned_ack, got.assigned_ack);
            if (got.close_request !== want.close_request)
               note_mismatch("close_request", want.close_request, got.close_request);
            if (got.freed_count !== want.freed_count)
               note_mismatch("freed_count", want.freed_count, got.freed_count);
            if (got.ack_to_return !== want.ack_to_return)
               note_mismatch("ack_to_return", want.ack_to_return, got.ack_to_return);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles = stuck_cycles + 1;
         if (stuck_cycles == STUCK_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
            $display("sliding_window_ack_tracker_tb: errors");
            $finish;
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      quiet        = 1'b0;
      hold_request = 1'b0;
      error_count   = 0;
      sent_count    = 0;
      checked_count = 0;
      stuck_cycles  = 0;
      flow_window    = FLOW_WINDOW_RST;
      urgent_reserve = URGENT_RESERVE_RST;
      for (int n = 0; n < NODES; n++) begin
         next_send[n]    = 8'd1;
         peer_acked[n]   = 8'd0;
         in_order_num[n] = 8'd0;
         for (int s = 0; s < SLOTS; s++) slot_num[n][s] = 8'd0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_status_cases();
      test_number_wrap();
      test_full_stall();
      test_mixed_traffic(7'd16, 7'd10, 110);
      test_mixed_traffic(7'd127, 7'd0, 110);
      test_mixed_traffic(7'd1, 7'd16, 110);
      test_mixed_traffic(CSR_DATA_W'($urandom_range(1, 127)),
                         CSR_DATA_W'($urandom_range(0, 16)), 110);

      repeat (SLOTS + 8) @(posedge clock);
      $display("run covered %0d requests and %0d responses: allocate, receive, unacknowledge,",
               sent_count, checked_count);
      $display("unused opcode, number wrap, window and slot limits, reserve settings, backpressure");
      if (error_count == 0) begin
         $display("sliding_window_ack_tracker_tb: clean");
      end else begin
         $display("sliding_window_ack_tracker_tb: errors");
      end
      $finish;
   end

endmodule

[files.f]
hdl/swat_pkg.sv
hdl/swat_slot_scan.sv
hdl/sliding_window_ack_tracker.sv
hdl/swat_port_checker.sv
test/sliding_window_ack_tracker_tb.sv
